// ===== design/lrs_pkg.sv =====
// lrs_pkg: shared types, codes and constants of the lcg random sampler
// no dependencies; used by lrs_ctrl, lrs_dp and lcg_random_sampler

package lrs_pkg;

   // generator constants
   localparam logic [31:0] LCG_MUL   = 32'd1103515245;
   localparam logic [31:0] LCG_ADD   = 32'd12345;
   localparam logic [31:0] LCG_SEED  = 32'd1;
   localparam int          DRAW_LSB  = 16;
   localparam int          DRAW_W    = 15;

   // q15 probabilities
   localparam int          PROB_W    = 16;
   localparam logic [15:0] Q15_ONE   = 16'd32768;
   localparam int          CUM_W     = 18;

   // item and word widths
   localparam int          VALUE_W   = 32;
   localparam int          OP_W      = 2;
   localparam int          REQ_DATA_W = 112;
   localparam int          RSP_DATA_W = 48;

   // remainder unit: one dividend bit per step
   localparam int          DIV_CNT_W = 4;
   localparam logic [3:0]  DIV_LAST  = 4'd14;

   // configuration registers
   localparam int          CSR_INDEX_W   = 3;
   localparam int          CSR_DATA_W    = 16;
   localparam int          COUNT_W       = 3;
   localparam logic [2:0]  CSR_OUT_COUNT = 3'd0;
   localparam logic [2:0]  CSR_PROB_BASE = 3'd1;
   localparam logic [2:0]  COUNT_RESET   = 3'd1;

   typedef enum logic [1:0] {
      OP_UNIFORM = 2'd0,
      OP_COIN    = 2'd1,
      OP_SELECT  = 2'd2,
      OP_RESEED  = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic reseed;
      logic advance;
      logic div_step;
      logic walk_step;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   empty_range;
      logic   walk_done;
   } dp_status_type;

   function automatic logic [15:0] sat_q15(input logic [15:0] v);
      sat_q15 = (v > Q15_ONE) ? Q15_ONE : v;
   endfunction

endpackage

// ===== design/lrs_dp.sv =====
// lrs_dp: generator state, item registers, bit-serial remainder, table walk
// and the result word register; depends on lrs_pkg

module lrs_dp #(
   parameter int MAX_OUTCOMES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lrs_pkg::op_type                     op_in,
   input  logic signed [lrs_pkg::VALUE_W-1:0]  low_bound,
   input  logic signed [lrs_pkg::VALUE_W-1:0]  high_bound,
   input  logic [lrs_pkg::PROB_W-1:0]          probability,
   input  logic [lrs_pkg::VALUE_W-1:0]         seed_value,
   input  logic                                csr_we,
   input  logic [lrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  lrs_pkg::dp_cmd_type                 cmd,
   output lrs_pkg::dp_status_type              status,
   output logic signed [lrs_pkg::VALUE_W-1:0]  result_value,
   output logic [lrs_pkg::DRAW_W-1:0]          raw_draw,
   output logic                                drew
);

   localparam int IDX_W = (MAX_OUTCOMES > 1) ? $clog2(MAX_OUTCOMES) : 1;
   localparam logic [lrs_pkg::COUNT_W-1:0] MAX_N = lrs_pkg::COUNT_W'(MAX_OUTCOMES);

   // generator and item registers
   logic [31:0]                        gen_ff;
   lrs_pkg::op_type                    op_ff;
   logic signed [31:0]                 low_ff;
   logic signed [31:0]                 high_ff;
   logic [15:0]                        prob_ff;
   logic [31:0]                        seed_ff;
   logic [32:0]                        span_ff;
   logic [lrs_pkg::DRAW_W-1:0]         draw_ff;
   logic                               drew_ff;

   // remainder unit
   logic [lrs_pkg::DRAW_W-1:0]         rem_ff;
   logic [lrs_pkg::DRAW_W-1:0]         dvd_ff;

   // table walk
   logic [lrs_pkg::COUNT_W-1:0]        count_ff;
   logic [15:0]                        tab_ff [MAX_OUTCOMES];
   logic [IDX_W-1:0]                   idx_ff;
   logic [lrs_pkg::CUM_W-1:0]          cum_ff;

   // result word
   logic signed [31:0]                 out_value_ff;
   logic [lrs_pkg::DRAW_W-1:0]         out_draw_ff;
   logic                               out_drew_ff;

   logic [31:0]                        lcg_prod;
   logic [31:0]                        gen_in;
   logic [31:0]                        span32;
   logic [lrs_pkg::DRAW_W:0]           trial;
   logic                               trial_fits;
   logic [lrs_pkg::CUM_W-1:0]          cum_in;
   logic [lrs_pkg::COUNT_W-1:0]        n_used;
   logic                               walk_hit;
   logic                               walk_last;
   logic signed [31:0]                 res_in;

   assign lcg_prod = gen_ff * lrs_pkg::LCG_MUL;
   assign gen_in   = lcg_prod + lrs_pkg::LCG_ADD;
   assign span32   = 32'(high_bound) - 32'(low_bound) + 32'd1;

   assign trial      = {rem_ff, dvd_ff[lrs_pkg::DRAW_W-1]};
   assign trial_fits = {17'd0, trial} >= span_ff;

   assign n_used = (count_ff == '0)  ? lrs_pkg::COUNT_W'(1) :
                   (count_ff > MAX_N) ? MAX_N : count_ff;
   assign cum_in    = cum_ff + lrs_pkg::CUM_W'(lrs_pkg::sat_q15(tab_ff[idx_ff]));
   assign walk_hit  = {3'd0, draw_ff} <= cum_in;
   assign walk_last = lrs_pkg::COUNT_W'(idx_ff) == (n_used - lrs_pkg::COUNT_W'(1));

   assign status.op          = op_ff;
   assign status.empty_range = low_ff >= high_ff;
   assign status.walk_done   = walk_hit || walk_last;

   always_comb begin
      case (op_ff)
         lrs_pkg::OP_UNIFORM: begin
            res_in = status.empty_range ? low_ff : (low_ff + $signed({17'd0, rem_ff}));
         end
         lrs_pkg::OP_COIN: begin
            res_in = ({1'b0, draw_ff} < lrs_pkg::sat_q15(prob_ff)) ? 32'sd1 : 32'sd0;
         end
         lrs_pkg::OP_SELECT: begin
            res_in = $signed(32'(idx_ff));
         end
         default: begin
            res_in = 32'sd0;
         end
      endcase
   end

   // generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= lrs_pkg::LCG_SEED;
      end else if (cmd.reseed) begin
         gen_ff <= seed_ff;
      end else if (cmd.advance) begin
         gen_ff <= gen_in;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= lrs_pkg::COUNT_RESET;
      end else if (csr_we && csr_index == lrs_pkg::CSR_OUT_COUNT) begin
         count_ff <= csr_wdata[lrs_pkg::COUNT_W-1:0];
      end
   end

   for (genvar i = 0; i < MAX_OUTCOMES; i++) begin : g_tab
      always_ff @(posedge clock) begin
         if (reset) begin
            tab_ff[i] <= (i == 0) ? lrs_pkg::Q15_ONE : 16'd0;
         end else if (csr_we &&
                      csr_index == lrs_pkg::CSR_PROB_BASE + lrs_pkg::CSR_INDEX_W'(i)) begin
            tab_ff[i] <= csr_wdata;
         end
      end
   end

   // item registers, draw, remainder and walk
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= op_in;
         low_ff  <= low_bound;
         high_ff <= high_bound;
         prob_ff <= probability;
         seed_ff <= seed_value;
         span_ff <= {span32 == 32'd0, span32};
      end
      if (cmd.load_item) begin
         draw_ff <= '0;
         drew_ff <= 1'b0;
      end else if (cmd.advance) begin
         draw_ff <= gen_in[lrs_pkg::DRAW_LSB +: lrs_pkg::DRAW_W];
         drew_ff <= 1'b1;
      end
      if (cmd.advance) begin
         rem_ff <= '0;
         dvd_ff <= gen_in[lrs_pkg::DRAW_LSB +: lrs_pkg::DRAW_W];
         idx_ff <= '0;
         cum_ff <= '0;
      end else begin
         if (cmd.div_step) begin
            rem_ff <= trial_fits ? lrs_pkg::DRAW_W'(trial - span_ff[lrs_pkg::DRAW_W:0])
                                 : trial[lrs_pkg::DRAW_W-1:0];
            dvd_ff <= dvd_ff << 1;
         end
         if (cmd.walk_step) begin
            cum_ff <= cum_in;
            if (!(walk_hit || walk_last)) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
      end
      if (cmd.out_load) begin
         out_value_ff <= res_in;
         out_draw_ff  <= draw_ff;
         out_drew_ff  <= drew_ff;
      end
   end

   assign result_value = out_value_ff;
   assign raw_draw     = out_draw_ff;
   assign drew         = out_drew_ff;

endmodule

// ===== design/lrs_ctrl.sv =====
// lrs_ctrl: one-hot sequencer of the sampler and owner of the result valid flag
// depends on lrs_pkg; drives lrs_dp through dp_cmd_type

module lrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  lrs_pkg::dp_status_type status,
   output lrs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DECODE  = 6'b000010,
      ST_ADVANCE = 6'b000100,
      ST_DIVIDE  = 6'b001000,
      ST_WALK    = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [lrs_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                            valid_ff, valid_in;
   logic                            out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      valid_in   = valid_ff && !rsp_tready;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op == lrs_pkg::OP_RESEED) begin
               cmd.reseed = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.op == lrs_pkg::OP_UNIFORM && status.empty_range) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            div_cnt_in  = lrs_pkg::DIV_LAST;
            case (status.op)
               lrs_pkg::OP_UNIFORM: state_in = ST_DIVIDE;
               lrs_pkg::OP_SELECT:  state_in = ST_WALK;
               default:             state_in = ST_FINISH;
            endcase
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff - lrs_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         valid_ff   <= valid_in;
      end
   end

   // result word never overwrites one still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!valid_ff || rsp_tready))
      else $error("result word loaded over a pending word");

   // an accepted word is decoded in the next cycle
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_DECODE)
      else $error("accepted word not decoded");

   // remainder steps only for a uniform draw
   a_div_uniform: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> status.op == lrs_pkg::OP_UNIFORM)
      else $error("remainder unit running for another operation");

   // table walk leaves only towards the result word
   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |=> (state_ff == ST_WALK || state_ff == ST_FINISH))
      else $error("table walk left to an unexpected state");

endmodule

// ===== design/lcg_random_sampler.sv =====
// lcg_random_sampler: top level of the 15-bit lcg sampler (uniform, coin flip,
// outcome select, reseed); depends on lrs_pkg, lrs_ctrl and lrs_dp
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+----------------------------------------
//  req_     | in        | tvalid / tready      | tuser: operation; tdata: bounds, prob, seed
//  rsp_     | out       | tvalid / tready      | tdata: result_value, raw_draw; tuser: drew
//  csr_     | in        | csr_we, no wait      | register index and write data
//
//  one word is worked on at a time; from accept to result load a word passes through
//    decode, then: reseed or empty uniform range go straight to the final state, a coin
//    flip goes via advance, outcome select via advance and k table walk steps
//    (at most MAX_OUTCOMES), uniform via advance and the 15-step bit-serial remainder unit
//  the next word is accepted in the cycle after the result is loaded, even while
//  that result still waits in the output register for rsp_tready
//  reset is synchronous: generator state 1, outcome count 1, table {one, 0, 0, 0}
//  a stalled result holds the sequencer in its final state until the output frees

module lcg_random_sampler #(
   parameter int MAX_OUTCOMES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lrs_pkg::REQ_DATA_W-1:0]     req_tdata,  // low_bound, high_bound,
                                                          // probability, seed_value
   input  logic [lrs_pkg::OP_W-1:0]           req_tuser,  // operation
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lrs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // result_value, raw_draw, zero pad
   output logic                               rsp_tuser,  // drew
   // configuration
   input  logic                               csr_we,
   input  logic [lrs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lrs_pkg::dp_cmd_type          cmd;
   lrs_pkg::dp_status_type       status;
   logic signed [31:0]           result_value;
   logic [lrs_pkg::DRAW_W-1:0]   raw_draw;
   logic                         drew;

   // sequencer: accept, decode, advance, remainder or walk, result load
   lrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // request word unpacked from the lowest bit up
   lrs_dp #(
      .MAX_OUTCOMES (MAX_OUTCOMES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .op_in        (lrs_pkg::op_type'(req_tuser)),
      .low_bound    ($signed(req_tdata[31:0])),
      .high_bound   ($signed(req_tdata[63:32])),
      .probability  (req_tdata[79:64]),
      .seed_value   (req_tdata[111:80]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .result_value (result_value),
      .raw_draw     (raw_draw),
      .drew         (drew)
   );

   // response word: value low, then the draw, topped up to whole bytes
   assign rsp_tdata = {1'b0, raw_draw, result_value};
   assign rsp_tuser = drew;

endmodule
